>>> rtl/core/voice_slot_allocator_assert.svh
// ----------------------------------------------------------------------------
// voice slot allocator assertion macros
// shared property forms for the allocator checks
// ----------------------------------------------------------------------------
`ifndef VOICE_SLOT_ALLOCATOR_ASSERT_SVH
`define VOICE_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define VSA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VSA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/vsa_pkg.sv
// ----------------------------------------------------------------------------
// vsa_pkg
// widths, command codes and sequencer states of the voice slot allocator
// ----------------------------------------------------------------------------
package vsa_pkg;

  localparam int SLOTS_DEFAULT = 32;

  localparam int FUNC_W  = 2;
  localparam int ID_W    = 64;
  localparam int SLOT_W  = 5;
  localparam int CNT_W   = 6;
  localparam int LIMIT_W = 6;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REL_ALL = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FIND    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } vsa_state_t;

endpackage

>>> rtl/core/vsa_if.sv
// ----------------------------------------------------------------------------
// vsa channel interfaces
// command, result and limit write channels with valid/ready
// ----------------------------------------------------------------------------
interface vsa_in_if
  import vsa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   block_id;

  modport source (output valid, output func, output block_id, input ready);
  modport sink   (input valid, input func, input block_id, output ready);
endinterface

interface vsa_out_if
  import vsa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  active_count;

  modport source (output valid, output ok, output slot, output active_count, input ready);
  modport sink   (input valid, input ok, input slot, input active_count, output ready);
endinterface

interface vsa_cfg_if
  import vsa_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] voice_limit;

  modport source (output valid, output voice_limit, input ready);
  modport sink   (input valid, input voice_limit, output ready);
endinterface

>>> rtl/core/voice_slot_allocator.sv
// ----------------------------------------------------------------------------
// voice_slot_allocator
// release all or zero limit skip the scan; other commands scan up to lim slots
// one command at a time (ready only in idle); the single owner-memory read port reads 1 slot/cycle
// reset (rst_n, synchronous): all slots free, count zero, limit min(32, SLOTS)
// ----------------------------------------------------------------------------
`include "voice_slot_allocator_assert.svh"

module voice_slot_allocator
  import vsa_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  vsa_in_if.sink     in_ch,
  vsa_out_if.source  out_ch,
  vsa_cfg_if.sink    cfg_ch
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = $clog2(SLOTS + 1);
  localparam int SW = LW + 1;
  localparam int CW = (LW > LIMIT_W) ? LW : LIMIT_W;
  localparam int RST_LIM = (SLOTS < 32) ? SLOTS : 32;

  vsa_state_t        st_r, st_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [LW-1:0]     lim_r, lim_nxt;
  logic [SLOTS-1:0]  busy_r, busy_nxt;
  logic [LW-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]     scan_idx_r, scan_idx_nxt;
  logic              issuing_r, issuing_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              cmp_last_r, cmp_last_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [IW-1:0]     res_slot_r, res_slot_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [ID_W-1:0]   owner_q_r;

  logic [ID_W-1:0]   owner_mem [SLOTS];

  logic in_acc, cfg_acc, last_issue, match, rd_en, mem_we;

  assign in_ch.ready         = (st_r == ST_IDLE);
  assign cfg_ch.ready        = (st_r == ST_IDLE);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign cfg_acc             = cfg_ch.valid && cfg_ch.ready;
  assign out_ch.valid        = out_vld_r;
  assign out_ch.ok           = out_ok_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.active_count = out_cnt_r;

  assign last_issue = (SW'(scan_idx_r) + SW'(1)) == SW'(lim_r);

  always_comb begin
    match = 1'b0;
    if (cmp_vld_r) begin
      if (func_r == FUNC_ALLOC) begin
        match = !busy_r[cmp_idx_r];
      end else begin
        match = busy_r[cmp_idx_r] && (owner_q_r == id_r);
      end
    end
  end

  always_comb begin
    st_nxt       = st_r;
    func_nxt     = func_r;
    id_nxt       = id_r;
    lim_nxt      = lim_r;
    busy_nxt     = busy_r;
    cnt_nxt      = cnt_r;
    scan_idx_nxt = scan_idx_r;
    issuing_nxt  = issuing_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    cmp_last_nxt = cmp_last_r;
    res_ok_nxt   = res_ok_r;
    res_slot_nxt = res_slot_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_ok_nxt   = out_ok_r;
    out_slot_nxt = out_slot_r;
    out_cnt_nxt  = out_cnt_r;
    rd_en        = 1'b0;
    mem_we       = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          func_nxt     = in_ch.func;
          id_nxt       = in_ch.block_id;
          res_slot_nxt = '0;
          if (in_ch.func == FUNC_REL_ALL) begin
            busy_nxt   = '0;
            cnt_nxt    = '0;
            res_ok_nxt = 1'b1;
            st_nxt     = ST_HOLD;
          end else if (lim_r == '0) begin
            res_ok_nxt = 1'b0;
            st_nxt     = ST_HOLD;
          end else begin
            scan_idx_nxt = '0;
            issuing_nxt  = 1'b1;
            st_nxt       = ST_SCAN;
          end
        end
        if (cfg_acc) begin
          if (CW'(cfg_ch.voice_limit) > CW'(SLOTS)) begin
            lim_nxt = LW'(SLOTS);
          end else begin
            lim_nxt = LW'(cfg_ch.voice_limit);
          end
          busy_nxt = '0;
          cnt_nxt  = '0;
        end
      end
      ST_SCAN: begin
        // read owner of the issued slot, compare the previous one
        rd_en        = issuing_r;
        cmp_vld_nxt  = issuing_r;
        cmp_idx_nxt  = scan_idx_r;
        cmp_last_nxt = last_issue;
        if (issuing_r) begin
          if (last_issue) begin
            issuing_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r + IW'(1);
          end
        end
        if (match) begin
          res_ok_nxt   = 1'b1;
          res_slot_nxt = cmp_idx_r;
          issuing_nxt  = 1'b0;
          cmp_vld_nxt  = 1'b0;
          st_nxt       = ST_HOLD;
          if (func_r == FUNC_ALLOC) begin
            busy_nxt[cmp_idx_r] = 1'b1;
            cnt_nxt             = cnt_r + LW'(1);
            mem_we              = 1'b1;
          end else if (func_r == FUNC_RELEASE) begin
            busy_nxt[cmp_idx_r] = 1'b0;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - LW'(1);
            end
          end
        end else if (cmp_vld_r && cmp_last_r) begin
          res_ok_nxt   = 1'b0;
          res_slot_nxt = '0;
          issuing_nxt  = 1'b0;
          cmp_vld_nxt  = 1'b0;
          st_nxt       = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt  = 1'b1;
          out_ok_nxt   = res_ok_r;
          out_slot_nxt = SLOT_W'(res_slot_r);
          out_cnt_nxt  = CNT_W'(cnt_r);
          st_nxt       = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      lim_r     <= LW'(RST_LIM);
      busy_r    <= '0;
      cnt_r     <= '0;
      issuing_r <= 1'b0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      lim_r     <= lim_nxt;
      busy_r    <= busy_nxt;
      cnt_r     <= cnt_nxt;
      issuing_r <= issuing_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    id_r       <= id_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    cmp_last_r <= cmp_last_nxt;
    res_ok_r   <= res_ok_nxt;
    res_slot_r <= res_slot_nxt;
    out_ok_r   <= out_ok_nxt;
    out_slot_r <= out_slot_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  // owner table, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      owner_mem[cmp_idx_r] <= id_r;
    end
    if (rd_en) begin
      owner_q_r <= owner_mem[scan_idx_r];
    end
  end

  `VSA_ASSERT_IMP(a_cnt_matches_marks, 1'b1, $countones(busy_r) == 32'(cnt_r), "busy count out of step with busy marks")
  `VSA_ASSERT_IMP(a_cnt_within_limit, 1'b1, cnt_r <= lim_r, "busy count above active limit")
  `VSA_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ch.ready, "command accepted while previous one in flight")
  `VSA_ASSERT_IMP(a_cmp_only_in_scan, cmp_vld_r, st_r == ST_SCAN, "compare stage live outside scan")

endmodule

>>> verif/voice_slot_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voice_slot_allocator_tb
// drives allocate, release, release-all and find beats through the command
// channel under several voice limits, takes each expected result from a
// directed row or a local copy of the slot table, compares each beat by field
// ----------------------------------------------------------------------------
module voice_slot_allocator_tb;
  import vsa_pkg::*;

  localparam int SLOT_COUNT  = SLOTS_DEFAULT;
  localparam int SETTLE      = 48;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int N_DIRECTED  = 24;
  localparam int N_PHASES    = 7;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  active_count;
  } voice_result_t;

  typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [FUNC_W-1:0]  func;
    logic [ID_W-1:0]    id;
    logic [LIMIT_W-1:0] limit;
    bit                 typed;
    logic               w_ok;
    logic [SLOT_W-1:0]  w_slot;
    logic [CNT_W-1:0]   w_cnt;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  vsa_in_if  cmd_bus ();
  vsa_out_if result_bus ();
  vsa_cfg_if limit_bus ();

  voice_slot_allocator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_bus),
    .out_ch (result_bus),
    .cfg_ch (limit_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // slot table as the block should hold it
  bit                 slot_taken [SLOT_COUNT];
  logic [ID_W-1:0]    slot_tag   [SLOT_COUNT];
  int unsigned        taken_count;
  logic [LIMIT_W-1:0] limit_reg;

  voice_result_t   pending_results [$];
  logic [ID_W-1:0] id_pool [8];
  int              error_count = 0;
  int              cycle_count = 0;
  bit              src_quiet   = 1'b0;
  bit              pressure_go = 1'b0;
  logic            sink_hold   = 1'b0;
  int              stall_left  = 0;
  int              quiet_left  = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_CMD, FUNC_FIND,    64'd0,                  6'd0,  1'b1, 1'b0, 5'd0, 6'd0},
    '{ROW_CMD, FUNC_REL_ALL, 64'd0,                  6'd0,  1'b1, 1'b1, 5'd0, 6'd0},
    '{ROW_CMD, FUNC_ALLOC,   64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 1'b1, 1'b1, 5'd0, 6'd1},
    '{ROW_CMD, FUNC_ALLOC,   64'd0,                  6'd0,  1'b1, 1'b1, 5'd1, 6'd2},
    '{ROW_CMD, FUNC_ALLOC,   64'd0,                  6'd0,  1'b1, 1'b1, 5'd2, 6'd3},
    '{ROW_CMD, FUNC_FIND,    64'd0,                  6'd0,  1'b1, 1'b1, 5'd1, 6'd3},
    '{ROW_CMD, FUNC_RELEASE, 64'd0,                  6'd0,  1'b1, 1'b1, 5'd1, 6'd2},
    '{ROW_CMD, FUNC_FIND,    64'd0,                  6'd0,  1'b1, 1'b1, 5'd2, 6'd2},
    '{ROW_CMD, FUNC_FIND,    64'h5555_5555_5555_5555, 6'd0, 1'b1, 1'b0, 5'd0, 6'd2},
    '{ROW_CMD, FUNC_RELEASE, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0, 1'b1, 1'b0, 5'd0, 6'd2},
    '{ROW_CMD, FUNC_ALLOC,   64'hAAAA_AAAA_AAAA_AAAA, 6'd0, 1'b1, 1'b1, 5'd1, 6'd3},
    '{ROW_CMD, FUNC_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 1'b1, 1'b1, 5'd0, 6'd2},
    '{ROW_CMD, FUNC_ALLOC,   64'h5555_5555_5555_5555, 6'd0, 1'b0, 1'b0, 5'd0, 6'd0},
    '{ROW_CMD, FUNC_REL_ALL, 64'h0123_4567_89AB_CDEF, 6'd0, 1'b1, 1'b1, 5'd0, 6'd0},
    '{ROW_CFG, FUNC_ALLOC,   64'd0,                  6'd0,  1'b0, 1'b0, 5'd0, 6'd0},
    '{ROW_CMD, FUNC_ALLOC,   64'd123,                6'd0,  1'b1, 1'b0, 5'd0, 6'd0},
    '{ROW_CMD, FUNC_FIND,    64'd123,                6'd0,  1'b1, 1'b0, 5'd0, 6'd0},
    '{ROW_CMD, FUNC_REL_ALL, 64'd0,                  6'd0,  1'b1, 1'b1, 5'd0, 6'd0},
    '{ROW_CFG, FUNC_ALLOC,   64'd0,                  6'd1,  1'b0, 1'b0, 5'd0, 6'd0},
    '{ROW_CMD, FUNC_ALLOC,   64'h8000_0000_0000_0001, 6'd0, 1'b1, 1'b1, 5'd0, 6'd1},
    '{ROW_CMD, FUNC_ALLOC,   64'h7FFF_FFFF_FFFF_FFFE, 6'd0, 1'b1, 1'b0, 5'd0, 6'd1},
    '{ROW_CMD, FUNC_FIND,    64'h8000_0000_0000_0001, 6'd0, 1'b0, 1'b0, 5'd0, 6'd0},
    '{ROW_CFG, FUNC_ALLOC,   64'd0,                  6'd63, 1'b0, 1'b0, 5'd0, 6'd0},
    '{ROW_CMD, FUNC_FIND,    64'h8000_0000_0000_0001, 6'd0, 1'b1, 1'b0, 5'd0, 6'd0}
  };

  logic [LIMIT_W-1:0] phase_limit [N_PHASES] = '{6'd63, 6'd3, 6'd32, 6'd0, 6'd1, 6'd17, 6'd63};
  int                 phase_items [N_PHASES] = '{400, 200, 400, 60, 150, 300, 140};

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < SLOT_COUNT; i++) slot_taken[i] = 1'b0;
    taken_count = 0;
  endfunction

  function automatic voice_result_t apply_command(input logic [FUNC_W-1:0] f,
                                                  input logic [ID_W-1:0] id);
    voice_result_t r;
    int lim;
    int hit;
    r   = '0;
    lim = (limit_reg > SLOT_COUNT) ? SLOT_COUNT : int'(limit_reg);
    hit = -1;
    case (f)
      FUNC_ALLOC: begin
        for (int i = 0; i < lim && hit < 0; i++)
          if (!slot_taken[i]) hit = i;
        if (hit >= 0) begin
          slot_taken[hit] = 1'b1;
          slot_tag[hit]   = id;
          taken_count++;
        end
      end
      FUNC_REL_ALL: begin
        clear_table();
        r.ok = 1'b1;
      end
      default: begin
        for (int i = 0; i < lim && hit < 0; i++)
          if (slot_taken[i] && slot_tag[i] == id) hit = i;
        if (hit >= 0 && f == FUNC_RELEASE) begin
          slot_taken[hit] = 1'b0;
          if (taken_count > 0) taken_count--;
        end
      end
    endcase
    if (hit >= 0) begin
      r.ok   = 1'b1;
      r.slot = hit[SLOT_W-1:0];
    end
    r.active_count = taken_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                 input logic [ID_W-1:0] want);
    if (error_count < 40)
      $display("mismatch %s: got %0d, expected %0d, cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                          input bit typed, input voice_result_t want);
    int gap;
    voice_result_t pred;
    gap = src_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid    <= 1'b1;
    cmd_bus.func     <= f;
    cmd_bus.block_id <= id;
    do @(posedge clk); while (!cmd_bus.ready);
    pred = apply_command(f, id);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cmd_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    limit_bus.valid       <= 1'b1;
    limit_bus.voice_limit <= v;
    do @(posedge clk); while (!limit_bus.ready);
    limit_bus.valid <= 1'b0;
    limit_reg = v;
    clear_table();
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) < 8) return id_pool[$urandom_range(0, 7)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 199);
    if (r < 90)  return FUNC_ALLOC;
    if (r < 140) return FUNC_RELEASE;
    if (r < 141) return FUNC_REL_ALL;
    return FUNC_FIND;
  endfunction

  // result beats against the oldest expectation
  always @(posedge clk) begin : result_check
    voice_result_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (result_bus.ok !== want.ok)
          report_mismatch("ok", result_bus.ok, want.ok);
        if (result_bus.slot !== want.slot)
          report_mismatch("slot", result_bus.slot, want.slot);
        if (result_bus.active_count !== want.active_count)
          report_mismatch("active_count", result_bus.active_count, want.active_count);
      end
    end
  end

  always @(posedge clk) begin : sink_pacing
    if (stall_left > 0) begin
      stall_left--;
    end else if (quiet_left > 0) begin
      quiet_left--;
    end else if ($urandom_range(0, 199) == 0) begin
      quiet_left = $urandom_range(100, 300);
    end else begin
      stall_left = pick_gap();
    end
    result_bus.ready <= !sink_hold && stall_left == 0;
  end

  // long receiver hold-off so the block backs up into the command channel
  initial begin
    wait (pressure_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (400) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t     row;
    voice_result_t want;
    rst_n                 = 1'b0;
    cmd_bus.valid         = 1'b0;
    cmd_bus.func          = FUNC_ALLOC;
    cmd_bus.block_id      = '0;
    result_bus.ready      = 1'b0;
    limit_bus.valid       = 1'b0;
    limit_bus.voice_limit = '0;
    limit_reg             = LIMIT_W'(SLOT_COUNT);
    clear_table();
    for (int i = 0; i < SLOT_COUNT; i++) slot_tag[i] = '0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < 8; i++) id_pool[i] = {$urandom, $urandom};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < N_DIRECTED; n++) begin
      row = directed_rows[n];
      if (row.kind == ROW_CFG) begin
        write_limit(row.limit);
      end else begin
        want = '{row.w_ok, row.w_slot, row.w_cnt};
        send_cmd(row.func, row.id, row.typed, want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_limit(phase_limit[p]);
      for (int k = 0; k < phase_items[p]; k++) begin
        if (k % 64 == 0) src_quiet = ($urandom_range(0, 3) == 0);
        if (p == 2 && k == 0) begin
          src_quiet   = 1'b1;
          pressure_go = 1'b1;
        end
        send_cmd(pick_func(), pick_id(), 1'b0, '0);
      end
    end

    cmd_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
